FILE: rtl/core/hdms_pkg.sv
// Shared types and constants for the hybrid drive mode selector.
package hdms_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_STOP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_HYBRID = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENGINE     = 3'd4;

    // Drive mode codes
    typedef enum logic [2:0] {
        MODE_STAND = 3'd0,
        MODE_EV    = 3'd1,
        MODE_REGEN = 3'd2,
        MODE_CRANK = 3'd3,
        MODE_ENG   = 3'd4,
        MODE_HYB   = 3'd5
    } t_mode;

    typedef struct packed {
        logic        [15:0] speed;
        logic signed [15:0] power;
        logic        [13:0] charge;
        logic        [15:0] engine;
    } t_sample;

    // Decoded thresholds
    typedef struct packed {
        logic        [15:0] s_stop;
        logic        [15:0] s_regen;
        logic        [15:0] s_evmax;
        logic signed [15:0] p_regen;
        logic signed [15:0] p_stoplo;
        logic signed [15:0] p_stophi;
        logic signed [15:0] p_hybin;
        logic signed [15:0] p_hybout;
        logic signed [15:0] p_hybmid;
        logic signed [15:0] p_hyblow;
        logic        [15:0] c_evin;
        logic        [15:0] c_evout;
        logic        [15:0] c_mid;
        logic        [15:0] c_low;
        logic        [15:0] e_on;
        logic        [15:0] e_off;
    } t_limits;

    // Threshold compare results
    typedef struct packed {
        logic spd_gt_stop;
        logic spd_gt_regen;
        logic spd_gt_evmax;
        logic pwr_le_regen;
        logic pwr_ge_stoplo;
        logic pwr_le_stophi;
        logic pwr_ge_hybin;
        logic pwr_le_hybout;
        logic pwr_ge_hybmid;
        logic pwr_le_hyblow;
        logic soc_ge_evin;
        logic soc_ge_evout;
        logic soc_ge_hyb;
        logic soc_ge_low;
        logic rpm_gt_on;
        logic rpm_le_off;
    } t_flags;

endpackage

FILE: rtl/core/hdms_cfg.sv
// Threshold register file with a plain write port.
module hdms_cfg
    import hdms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_limits               o_limits
);

    logic [47:0] r_speed;
    logic [47:0] r_pwr_stop;
    logic [63:0] r_pwr_hyb;
    logic [63:0] r_charge;
    logic [31:0] r_engine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= '0;
            r_pwr_stop <= '0;
            r_pwr_hyb  <= '0;
            r_charge   <= '0;
            r_engine   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED:      r_speed    <= i_cfg_data[47:0];
                CFG_PWR_STOP:   r_pwr_stop <= i_cfg_data[47:0];
                CFG_PWR_HYBRID: r_pwr_hyb  <= i_cfg_data;
                CFG_CHARGE:     r_charge   <= i_cfg_data;
                CFG_ENGINE:     r_engine   <= i_cfg_data[31:0];
                default: ;   // unknown index: write dropped
            endcase
        end
    end

    always_comb begin
        o_limits.s_stop   = r_speed[15:0];
        o_limits.s_regen  = r_speed[31:16];
        o_limits.s_evmax  = r_speed[47:32];
        o_limits.p_regen  = r_pwr_stop[15:0];
        o_limits.p_stoplo = r_pwr_stop[31:16];
        o_limits.p_stophi = r_pwr_stop[47:32];
        o_limits.p_hybin  = r_pwr_hyb[15:0];
        o_limits.p_hybout = r_pwr_hyb[31:16];
        o_limits.p_hybmid = r_pwr_hyb[47:32];
        o_limits.p_hyblow = r_pwr_hyb[63:48];
        o_limits.c_evin   = r_charge[15:0];
        o_limits.c_evout  = r_charge[31:16];
        o_limits.c_mid    = r_charge[47:32];
        o_limits.c_low    = r_charge[63:48];
        o_limits.e_on     = r_engine[15:0];
        o_limits.e_off    = r_engine[31:16];
    end

endmodule

FILE: rtl/core/hdms_cmp.sv
// Sample-versus-threshold comparator bank.
module hdms_cmp
    import hdms_pkg::*;
(
    input  t_sample i_sample,
    input  t_limits i_limits,
    output t_flags  o_flags
);

    logic [15:0] w_soc;

    assign w_soc = {2'b00, i_sample.charge};

    always_comb begin
        o_flags.spd_gt_stop   = i_sample.speed > i_limits.s_stop;
        o_flags.spd_gt_regen  = i_sample.speed > i_limits.s_regen;
        o_flags.spd_gt_evmax  = i_sample.speed > i_limits.s_evmax;
        // power compares are signed on both sides
        o_flags.pwr_le_regen  = i_sample.power <= i_limits.p_regen;
        o_flags.pwr_ge_stoplo = i_sample.power >= i_limits.p_stoplo;
        o_flags.pwr_le_stophi = i_sample.power <= i_limits.p_stophi;
        o_flags.pwr_ge_hybin  = i_sample.power >= i_limits.p_hybin;
        o_flags.pwr_le_hybout = i_sample.power <= i_limits.p_hybout;
        o_flags.pwr_ge_hybmid = i_sample.power >= i_limits.p_hybmid;
        o_flags.pwr_le_hyblow = i_sample.power <= i_limits.p_hyblow;
        o_flags.soc_ge_evin   = w_soc >= i_limits.c_evin;
        o_flags.soc_ge_evout  = w_soc >= i_limits.c_evout;
        o_flags.soc_ge_hyb    = w_soc >= i_limits.c_mid;
        o_flags.soc_ge_low    = w_soc >= i_limits.c_low;
        o_flags.rpm_gt_on     = i_sample.engine > i_limits.e_on;
        o_flags.rpm_le_off    = i_sample.engine <= i_limits.e_off;
    end

endmodule

FILE: rtl/core/hdms_fsm.sv
// Drive mode register, guard priority logic and result register.
module hdms_fsm
    import hdms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_flags                i_flags,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [OUT_DATA_W-1:0] o_tdata
);

    t_mode                 r_mode;
    t_mode                 n_mode;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic                  w_adv;
    logic                  w_to_regen;
    logic                  w_to_stand;
    logic                  w_ev_ok;
    logic                  w_exit_ev;
    logic                  w_mot;
    logic                  w_gen;
    logic                  w_eng;

    assign o_ready  = !r_out_valid || i_tready;
    assign w_adv    = i_valid && o_ready;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    assign w_to_regen = i_flags.spd_gt_regen && i_flags.pwr_le_regen;
    assign w_to_stand = !i_flags.spd_gt_stop && i_flags.pwr_le_stophi
                        && i_flags.pwr_ge_stoplo;
    assign w_ev_ok    = i_flags.spd_gt_stop && !i_flags.spd_gt_evmax
                        && i_flags.soc_ge_evin;
    // shared engine-mode exit to electric
    assign w_exit_ev  = i_flags.rpm_gt_on && i_flags.pwr_le_hybout
                        && i_flags.pwr_ge_stoplo && w_ev_ok;

    always_comb begin
        n_mode = r_mode;
        unique case (r_mode) inside
            MODE_STAND: begin
                if (w_ev_ok)                  n_mode = MODE_EV;
                else if (i_flags.spd_gt_stop) n_mode = MODE_CRANK;
                else                          n_mode = MODE_STAND;
            end
            MODE_EV: begin
                if (w_to_regen)
                    n_mode = MODE_REGEN;
                else if (i_flags.spd_gt_evmax || i_flags.pwr_ge_hybin
                         || !i_flags.soc_ge_evout)
                    n_mode = MODE_CRANK;
                else if (w_to_stand)
                    n_mode = MODE_STAND;
                else
                    n_mode = MODE_EV;
            end
            MODE_REGEN: begin
                if ((i_flags.spd_gt_evmax && i_flags.pwr_ge_stoplo)
                    || !i_flags.soc_ge_evout)
                    n_mode = MODE_CRANK;
                else if (w_to_stand)
                    n_mode = MODE_STAND;
                else if (i_flags.pwr_ge_stoplo && i_flags.spd_gt_stop)
                    n_mode = MODE_EV;
                else
                    n_mode = MODE_REGEN;
            end
            MODE_CRANK, MODE_ENG, MODE_HYB: begin
                if (i_flags.rpm_gt_on && w_to_regen)
                    n_mode = MODE_REGEN;
                else if (w_exit_ev)
                    n_mode = MODE_EV;
                else if (w_to_stand)
                    n_mode = MODE_STAND;
                else if (r_mode == MODE_CRANK) begin
                    if (i_flags.rpm_gt_on && i_flags.soc_ge_hyb
                        && (i_flags.spd_gt_evmax || i_flags.pwr_ge_hybmid))
                        n_mode = MODE_HYB;
                    else if (i_flags.rpm_gt_on)
                        n_mode = MODE_ENG;
                    else
                        n_mode = MODE_CRANK;
                end else if (i_flags.rpm_le_off)
                    n_mode = MODE_CRANK;   // engine stall
                else if (r_mode == MODE_ENG) begin
                    if (i_flags.pwr_ge_hybmid && i_flags.soc_ge_hyb)
                        n_mode = MODE_HYB;
                    else
                        n_mode = MODE_ENG;
                end else begin
                    if (i_flags.pwr_le_hyblow || !i_flags.soc_ge_low)
                        n_mode = MODE_ENG;
                    else
                        n_mode = MODE_HYB;
                end
            end
            default: n_mode = MODE_STAND;
        endcase
    end

    always_comb begin
        case (n_mode) inside
            MODE_EV, MODE_REGEN, MODE_CRANK, MODE_HYB: w_mot = 1'b1;
            default:                                   w_mot = 1'b0;
        endcase
        case (n_mode) inside
            MODE_CRANK, MODE_ENG, MODE_HYB: w_gen = 1'b1;
            default:                        w_gen = 1'b0;
        endcase
        case (n_mode) inside
            MODE_ENG, MODE_HYB: w_eng = 1'b1;
            default:            w_eng = 1'b0;
        endcase
        n_out_data = {2'b00, w_eng, w_gen, w_mot, n_mode};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STAND;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_mode <= n_mode;
            end
            r_out_valid <= w_adv || (r_out_valid && !i_tready);
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

FILE: rtl/core/hybrid_drive_mode_selector_top.sv
// Top level of the hybrid drive mode selector.
// One sample transfer in gives one result transfer out, and a sample can be
// taken every clock while the result side is not stalled: the sample lands in
// an input register, the comparator bank and mode guards evaluate it from that
// register, and the new mode with its motor, generator and engine enables is
// loaded into the output register, so throughput is one sample per cycle while m_axis_tready holds. The mode
// register resets to standstill and all thresholds reset to zero; thresholds
// should be written only while no sample is in flight.
module hybrid_drive_mode_selector_top
    import hdms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] vehicle_speed, [31:16] power_demand, [45:32] battery_charge,
    // [61:46] engine_speed, [63:62] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] drive_mode, [3] motor_enable, [4] generator_enable,
    // [5] engine_enable, [7:6] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic    r_in_valid;
    t_sample r_sample;
    logic    w_fsm_ready;
    t_limits w_limits;
    t_flags  w_flags;

    assign s_axis_tready = !r_in_valid || w_fsm_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_sample.speed  <= s_axis_tdata[15:0];
            r_sample.power  <= s_axis_tdata[31:16];
            r_sample.charge <= s_axis_tdata[45:32];
            r_sample.engine <= s_axis_tdata[61:46];
        end
    end

    hdms_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_limits   (w_limits)
    );

    hdms_cmp u_cmp (
        .i_sample (r_sample),
        .i_limits (w_limits),
        .o_flags  (w_flags)
    );

    hdms_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_ready  (w_fsm_ready),
        .i_flags  (w_flags),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

FILE: tb/drive_mode_checker.sv
// Scoreboard for the drive mode selector: predicts each mode and compares results.
`timescale 1ns / 1ps

module drive_mode_checker
    import hdms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        t_mode mode;
        logic  motor;
        logic  gen;
        logic  engine;
    } t_drive_cmd;

    logic [47:0] lim_speed;
    logic [47:0] lim_pwr_stop;
    logic [63:0] lim_pwr_hyb;
    logic [63:0] lim_charge;
    logic [31:0] lim_engine;
    t_mode       held_mode;
    t_drive_cmd  expected_cmds [$];
    int          err_cnt;

    assign o_errors = err_cnt;

    function automatic t_mode next_drive_mode(input logic [IN_DATA_W-1:0] d, input t_mode cur);
        logic        [15:0] spd;
        logic signed [15:0] pwr;
        logic        [15:0] soc;
        logic        [15:0] rpm;
        logic signed [15:0] p_regen, p_stoplo, p_stophi, p_hybin, p_hybout, p_hybmid, p_hyblow;
        logic        [15:0] s_stop, s_regen, s_evmax, c_evin, c_evout, c_mid, c_low, e_on, e_off;
        logic               to_regen, to_stand, ev_ok, on, off;
        t_mode              nxt;
        spd      = d[15:0];
        pwr      = d[31:16];
        soc      = {2'b00, d[45:32]};
        rpm      = d[61:46];
        s_stop   = lim_speed[15:0];
        s_regen  = lim_speed[31:16];
        s_evmax  = lim_speed[47:32];
        p_regen  = lim_pwr_stop[15:0];
        p_stoplo = lim_pwr_stop[31:16];
        p_stophi = lim_pwr_stop[47:32];
        p_hybin  = lim_pwr_hyb[15:0];
        p_hybout = lim_pwr_hyb[31:16];
        p_hybmid = lim_pwr_hyb[47:32];
        p_hyblow = lim_pwr_hyb[63:48];
        c_evin   = lim_charge[15:0];
        c_evout  = lim_charge[31:16];
        c_mid    = lim_charge[47:32];
        c_low    = lim_charge[63:48];
        e_on     = lim_engine[15:0];
        e_off    = lim_engine[31:16];

        on       = rpm > e_on;
        off      = rpm <= e_off;
        to_regen = spd > s_regen && pwr <= p_regen;
        to_stand = spd <= s_stop && pwr <= p_stophi && pwr >= p_stoplo;
        ev_ok    = spd > s_stop && spd <= s_evmax && soc >= c_evin;
        nxt      = cur;
        case (cur) inside
            MODE_STAND: begin
                if (ev_ok)             nxt = MODE_EV;
                else if (spd > s_stop) nxt = MODE_CRANK;
            end
            MODE_EV: begin
                if (to_regen)                                         nxt = MODE_REGEN;
                else if (spd > s_evmax || pwr >= p_hybin || soc < c_evout) nxt = MODE_CRANK;
                else if (to_stand)                                    nxt = MODE_STAND;
            end
            MODE_REGEN: begin
                if ((spd > s_evmax && pwr >= p_stoplo) || soc < c_evout) nxt = MODE_CRANK;
                else if (to_stand)                          nxt = MODE_STAND;
                else if (pwr >= p_stoplo && spd > s_stop)   nxt = MODE_EV;
            end
            MODE_CRANK, MODE_ENG, MODE_HYB: begin
                // common engine exits take priority over the per-mode moves
                if (on && to_regen)                                      nxt = MODE_REGEN;
                else if (on && pwr <= p_hybout && pwr >= p_stoplo && ev_ok) nxt = MODE_EV;
                else if (to_stand)                                       nxt = MODE_STAND;
                else if (cur == MODE_CRANK) begin
                    if (on && soc >= c_mid && (spd > s_evmax || pwr >= p_hybmid)) nxt = MODE_HYB;
                    else if (on) nxt = MODE_ENG;
                end else if (cur == MODE_ENG) begin
                    if (off)                                nxt = MODE_CRANK;
                    else if (pwr >= p_hybmid && soc >= c_mid) nxt = MODE_HYB;
                end else begin
                    if (off)                                nxt = MODE_CRANK;
                    else if (pwr <= p_hyblow || soc < c_low) nxt = MODE_ENG;
                end
            end
            default: nxt = MODE_STAND;
        endcase
        return nxt;
    endfunction

    always @(posedge i_clk) begin
        t_drive_cmd e;
        if (!i_rst_n) begin
            lim_speed    = '0;
            lim_pwr_stop = '0;
            lim_pwr_hyb  = '0;
            lim_charge   = '0;
            lim_engine   = '0;
            held_mode    = MODE_STAND;
            err_cnt      = 0;
            expected_cmds.delete();
            o_pending   <= 0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPEED:      lim_speed    = i_cfg_data[47:0];
                    CFG_PWR_STOP:   lim_pwr_stop = i_cfg_data[47:0];
                    CFG_PWR_HYBRID: lim_pwr_hyb  = i_cfg_data;
                    CFG_CHARGE:     lim_charge   = i_cfg_data;
                    CFG_ENGINE:     lim_engine   = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_cmds.size() == 0) begin
                    err_cnt++;
                    $error("result transfer with nothing expected, data 0x%h", i_out_data);
                end else begin
                    e = expected_cmds.pop_front();
                    if (i_out_data[2:0] !== e.mode) begin
                        err_cnt++;
                        $error("drive_mode: expected %0d, got %0d", e.mode, i_out_data[2:0]);
                    end
                    if (i_out_data[3] !== e.motor) begin
                        err_cnt++;
                        $error("motor_enable: expected %0b, got %0b", e.motor, i_out_data[3]);
                    end
                    if (i_out_data[4] !== e.gen) begin
                        err_cnt++;
                        $error("generator_enable: expected %0b, got %0b", e.gen, i_out_data[4]);
                    end
                    if (i_out_data[5] !== e.engine) begin
                        err_cnt++;
                        $error("engine_enable: expected %0b, got %0b", e.engine, i_out_data[5]);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                held_mode = next_drive_mode(i_in_data, held_mode);
                e.mode    = held_mode;
                e.motor   = held_mode inside {MODE_EV, MODE_REGEN, MODE_CRANK, MODE_HYB};
                e.gen     = held_mode inside {MODE_CRANK, MODE_ENG, MODE_HYB};
                e.engine  = held_mode inside {MODE_ENG, MODE_HYB};
                expected_cmds.push_back(e);
            end
            o_pending <= expected_cmds.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Stimulus and verdict for the hybrid drive mode selector.
`timescale 1ns / 1ps

module testbench
    import hdms_pkg::*;
();

    typedef enum int {
        PROF_ZERO,
        PROF_SANE,
        PROF_ONES,
        PROF_EDGE,
        PROF_RAND
    } t_profile;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    errors;
    int                    pending;

    // thresholds in register order: s_stop, s_regen, s_evmax, p_regen, p_stoplo,
    // p_stophi, p_hybin, p_hybout, p_hybmid, p_hyblow, c_evin, c_evout, c_mid,
    // c_low, e_on, e_off
    logic [15:0] lim [16];
    logic [15:0] last_spd, last_pwr, last_soc, last_rpm;
    bit          no_gaps;

    always #6 i_clk = ~i_clk;

    hybrid_drive_mode_selector_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    drive_mode_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function automatic int unsigned pick_gap(input bit sender);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sender && no_gaps) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Field values mostly hold or sit next to a threshold, so guards get exercised.
    function automatic logic [15:0] roll_field(input logic [15:0] prev, input logic [15:0] pt);
        int unsigned r;
        logic [15:0] d;
        r = $urandom_range(0, 99);
        d = 16'($urandom_range(0, 6));
        if (r < 40) return prev;
        if (r < 85) return pt + d - 16'd3;
        if (r < 92) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic send_sample(input int spd, input int pwr, input int soc, input int rpm);
        int unsigned gap;
        gap      = pick_gap(1'b1);
        last_spd = spd[15:0];
        last_pwr = pwr[15:0];
        last_soc = {2'b00, soc[13:0]};
        last_rpm = rpm[15:0];
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, last_rpm, last_soc[13:0], last_pwr, last_spd};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold off until every sample in flight has produced its result.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_limits();
        logic [63:0]          w  [6];
        logic [CFG_IDX_W-1:0] ix [6];
        logic [31:0]          r1, r2;
        logic [2:0]           off;
        r1    = $urandom;
        r2    = $urandom;
        off   = 3'($urandom_range(1, 3));
        w[0]  = {r1[15:0], lim[2], lim[1], lim[0]};
        w[1]  = {r1[31:16], lim[5], lim[4], lim[3]};
        w[2]  = {lim[9], lim[8], lim[7], lim[6]};
        w[3]  = {lim[13], lim[12], lim[11], lim[10]};
        w[4]  = {r2, lim[15], lim[14]};
        w[5]  = {$urandom, $urandom};
        ix[0] = CFG_SPEED;
        ix[1] = CFG_PWR_STOP;
        ix[2] = CFG_PWR_HYBRID;
        ix[3] = CFG_CHARGE;
        ix[4] = CFG_ENGINE;
        ix[5] = CFG_ENGINE + off;   // unmapped index, must be ignored
        for (int k = 0; k < 6; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= ix[k];
            i_cfg_data <= w[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_profile(input t_profile kind);
        int v;
        case (kind)
            PROF_ZERO: begin
                foreach (lim[k]) lim[k] = 16'h0000;
            end
            PROF_ONES: begin
                foreach (lim[k]) lim[k] = 16'hFFFF;
            end
            PROF_EDGE: begin
                foreach (lim[k]) begin
                    if (k >= 3 && k <= 9)
                        lim[k] = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
                    else
                        lim[k] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                end
            end
            PROF_RAND: begin
                foreach (lim[k]) lim[k] = 16'($urandom);
            end
            default: begin
                lim[0]  = 16'($urandom_range(0, 100));
                lim[1]  = lim[0] + 16'($urandom_range(0, 200));
                lim[2]  = lim[1] + 16'($urandom_range(100, 2000));
                v       = $urandom_range(10, 500);
                lim[3]  = 16'(-v);
                v       = $urandom_range(0, 50);
                lim[4]  = 16'(-v);
                lim[5]  = 16'($urandom_range(0, 50));
                lim[6]  = 16'($urandom_range(100, 800));
                lim[7]  = lim[6] - 16'($urandom_range(0, 100));
                lim[8]  = 16'($urandom_range(50, 600));
                lim[9]  = lim[8] - 16'($urandom_range(0, 100));
                lim[10] = 16'($urandom_range(5000, 8000));
                lim[11] = lim[10] - 16'($urandom_range(0, 2000));
                lim[12] = 16'($urandom_range(2000, 5000));
                lim[13] = lim[12] - 16'($urandom_range(0, 1500));
                lim[14] = 16'($urandom_range(500, 1500));
                lim[15] = lim[14] - 16'($urandom_range(0, 400));
            end
        endcase
    endtask

    // result side: ready bursts broken by stalls, now and then a long clean run
    initial begin
        forever begin
            m_axis_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30)) @(posedge i_clk);
            m_axis_tready <= 1'b0;
            repeat (pick_gap(1'b0) + 1) @(posedge i_clk);
        end
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_profile plan [8];
        plan = '{PROF_SANE, PROF_ONES, PROF_SANE, PROF_RAND,
                 PROF_EDGE, PROF_SANE, PROF_ZERO, PROF_SANE};
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        no_gaps        = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // thresholds still at reset: field extremes
        send_sample(0, 0, 0, 0);
        send_sample(65535, 32767, 16383, 65535);
        send_sample(0, -32768, 0, 0);
        send_sample(65535, -32768, 10000, 0);
        drain();

        lim = '{16'd20, 16'd50, 16'd500, -16'sd100, -16'sd20, 16'd20, 16'd400, 16'd300,
                16'd200, 16'd50, 16'd6000, 16'd4000, 16'd3000, 16'd2000, 16'd800, 16'd300};
        load_limits();
        // walk through every mode
        send_sample(0, 0, 5000, 0);
        send_sample(100, 50, 9000, 0);
        send_sample(100, -200, 9000, 0);
        send_sample(100, 0, 9000, 0);
        send_sample(600, 100, 9000, 0);
        send_sample(600, 100, 9000, 1000);
        send_sample(600, 20, 9000, 1000);
        send_sample(600, 300, 9000, 1000);
        send_sample(600, 300, 9000, 100);
        send_sample(600, 300, 1000, 1000);
        send_sample(600, 300, 1000, 100);
        send_sample(0, 0, 1000, 0);
        send_sample(100, 0, 1000, 0);
        send_sample(100, 0, 9000, 1000);
        send_sample(100, 500, 9000, 0);
        send_sample(100, -200, 9000, 1000);
        send_sample(100, -200, 1000, 0);
        send_sample(0, 0, 16383, 0);           // charge at full scale of its 14-bit field
        send_sample(65535, 32767, 16383, 65535);
        send_sample(65535, -32768, 0, 0);
        send_sample(0, -32768, 0, 65535);
        send_sample(0, 0, 0, 0);

        foreach (plan[p]) begin
            drain();
            set_profile(plan[p]);
            load_limits();
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 250; n++) begin
                send_sample(roll_field(last_spd, lim[$urandom_range(0, 2)]),
                            roll_field(last_pwr, lim[$urandom_range(3, 9)]),
                            roll_field(last_soc, lim[$urandom_range(10, 13)]),
                            roll_field(last_rpm, lim[$urandom_range(14, 15)]));
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
